// ===== rtl/tltt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tltt_pkg
// Shared widths, register map and types for the thick line expander.
// ----------------------------------------------------------------------------
package tltt_pkg;

	localparam int THICK_W  = 16;               // thickness field
	localparam int COLOR_W  = 32;               // packed RGBA
	localparam int NORM_W   = 24;               // normalized |dx|,|dy| width
	localparam int SQ_W     = 2 * NORM_W + 1;   // ax^2 + ay^2
	localparam int LEN_FRAC = 14;               // extra radicand shift
	localparam int RAD_W    = SQ_W + LEN_FRAC;  // sqrt radicand
	localparam int ROOT_W   = (RAD_W + 1) / 2;  // length, 7 extra frac bits
	localparam int PROD_W   = THICK_W + NORM_W; // thickness * magnitude
	localparam int NUM_SH   = 7;                // *64, then *2 for rounding
	localparam int NUM_W    = PROD_W + NUM_SH + 1;
	localparam int DEN_W    = ROOT_W + 1;       // 2 * length
	localparam int QUO_W    = THICK_W;          // offset magnitude
	localparam int OFS_W    = QUO_W + 1;        // signed offset

	// APB register map
	localparam int PADDR_W     = 3;
	localparam int APB_W       = 32;
	localparam int REG_IDX_LSB = 2;
	localparam logic [PADDR_W-REG_IDX_LSB-1:0] REG_GEOM_COLOR = '0;
	localparam logic [COLOR_W-1:0] COLOR_RST = '1;

	typedef enum logic {
		TRI_FIRST,
		TRI_SECOND
	} tri_sel_t;

endpackage
`default_nettype wire

// ===== rtl/tltt_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tltt_if
// Valid/ready channels: segment requests in, triangle requests out.
// ----------------------------------------------------------------------------
interface tltt_seg_if #(parameter int CW = 24);
	logic                             valid;
	logic                             ready;
	logic signed [CW-1:0]             start_x;
	logic signed [CW-1:0]             start_y;
	logic signed [CW-1:0]             end_x;
	logic signed [CW-1:0]             end_y;
	logic [tltt_pkg::THICK_W-1:0]     thickness;

	modport source (output valid, start_x, start_y, end_x, end_y, thickness,
		input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, thickness,
		output ready);
endinterface

interface tltt_tri_if #(parameter int CW = 24);
	logic                             valid;
	logic                             ready;
	logic signed [CW-1:0]             vert_a_x;
	logic signed [CW-1:0]             vert_a_y;
	logic signed [CW-1:0]             vert_b_x;
	logic signed [CW-1:0]             vert_b_y;
	logic signed [CW-1:0]             vert_c_x;
	logic signed [CW-1:0]             vert_c_y;
	logic [tltt_pkg::COLOR_W-1:0]     tri_color;
	logic                             last_triangle;

	modport source (output valid, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
		vert_c_x, vert_c_y, tri_color, last_triangle, input ready);
	modport sink (input valid, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
		vert_c_x, vert_c_y, tri_color, last_triangle, output ready);
endinterface
`default_nettype wire

// ===== rtl/tltt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tltt_front
// Direction, magnitude normalization, squares and thickness products.
// Six stages, all held by en.
// ----------------------------------------------------------------------------
module tltt_front #(
	parameter int CW = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_in,
	input  logic signed [CW-1:0]           sx,
	input  logic signed [CW-1:0]           sy,
	input  logic signed [CW-1:0]           ex,
	input  logic signed [CW-1:0]           ey,
	input  logic [tltt_pkg::THICK_W-1:0]   th,
	output logic                           v_out,
	output logic signed [CW-1:0]           sx_o,
	output logic signed [CW-1:0]           sy_o,
	output logic signed [CW-1:0]           ex_o,
	output logic signed [CW-1:0]           ey_o,
	output logic                           nx_o,
	output logic                           ny_o,
	output logic [tltt_pkg::RAD_W-1:0]     rad_o,
	output logic [tltt_pkg::PROD_W-1:0]    px_o,
	output logic [tltt_pkg::PROD_W-1:0]    py_o
);
	import tltt_pkg::*;

	localparam int DW     = CW + 1;
	localparam int MAG_W  = (DW > NORM_W) ? DW : NORM_W;
	localparam int LEAD_W = $clog2(MAG_W);

	typedef struct packed {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
	} pts_t;

	function automatic logic [LEAD_W-1:0] lead_one(input logic [MAG_W-1:0] v);
		logic [LEAD_W-1:0] p;
		p = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (v[i]) p = LEAD_W'(i);
		end
		return p;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	pts_t pt_s1, pt_s2, pt_s3, pt_s4, pt_s5, pt_s6;
	logic [THICK_W-1:0] th_s1, th_s2, th_s3, th_s4;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [MAG_W-1:0] ax_s2, ay_s2, m_s2, ax_s3, ay_s3;
	logic nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4, nx_s5, ny_s5, nx_s6, ny_s6;
	logic [LEAD_W-1:0] lead_s3;
	logic [NORM_W-1:0] ax_s4, ay_s4;
	logic [2*NORM_W-1:0] sqx_s5, sqy_s5;
	logic [PROD_W-1:0] px_s5, py_s5, px_s6, py_s6;
	logic [RAD_W-1:0] rad_s6;

	// stage 2 combinational: magnitudes, zero-length fixup
	logic [MAG_W-1:0] ax_c, ay_c;
	logic zero_c;
	// stage 4 combinational: normalizing shift
	logic [MAG_W-1:0] axn_c, ayn_c;

	always_comb begin
		zero_c = (dx_s1 == '0) && (dy_s1 == '0);
		ax_c = dx_s1[DW-1] ? MAG_W'(-dx_s1) : MAG_W'(dx_s1);
		ay_c = dy_s1[DW-1] ? MAG_W'(-dy_s1) : MAG_W'(dy_s1);
		if (zero_c) ax_c = MAG_W'(1) << (NORM_W - 1);
	end

	always_comb begin
		if (lead_s3 >= LEAD_W'(NORM_W - 1)) begin
			axn_c = ax_s3 >> (lead_s3 - LEAD_W'(NORM_W - 1));
			ayn_c = ay_s3 >> (lead_s3 - LEAD_W'(NORM_W - 1));
		end else begin
			axn_c = ax_s3 << (LEAD_W'(NORM_W - 1) - lead_s3);
			ayn_c = ay_s3 << (LEAD_W'(NORM_W - 1) - lead_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: differences
			pt_s1 <= '{sx: sx, sy: sy, ex: ex, ey: ey};
			th_s1 <= th;
			dx_s1 <= DW'(ex) - DW'(sx);
			dy_s1 <= DW'(ey) - DW'(sy);
			// s2: magnitudes, signs, larger one
			pt_s2 <= pt_s1;
			th_s2 <= th_s1;
			ax_s2 <= ax_c;
			ay_s2 <= ay_c;
			nx_s2 <= dx_s1[DW-1];
			ny_s2 <= dy_s1[DW-1];
			m_s2  <= (ax_c > ay_c) ? ax_c : ay_c;
			// s3: leading one
			pt_s3   <= pt_s2;
			th_s3   <= th_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;
			lead_s3 <= lead_one(m_s2);
			// s4: larger magnitude into [2^23, 2^24)
			pt_s4 <= pt_s3;
			th_s4 <= th_s3;
			ax_s4 <= axn_c[NORM_W-1:0];
			ay_s4 <= ayn_c[NORM_W-1:0];
			nx_s4 <= nx_s3;
			ny_s4 <= ny_s3;
			// s5: squares and thickness products
			pt_s5  <= pt_s4;
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
			sqx_s5 <= ax_s4 * ax_s4;
			sqy_s5 <= ay_s4 * ay_s4;
			px_s5  <= th_s4 * ay_s4;
			py_s5  <= th_s4 * ax_s4;
			// s6: radicand
			pt_s6  <= pt_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			px_s6  <= px_s5;
			py_s6  <= py_s5;
			rad_s6 <= {({1'b0, sqx_s5} + {1'b0, sqy_s5}), {LEN_FRAC{1'b0}}};
		end
	end

	assign v_out = v_s6;
	assign sx_o  = pt_s6.sx;
	assign sy_o  = pt_s6.sy;
	assign ex_o  = pt_s6.ex;
	assign ey_o  = pt_s6.ey;
	assign nx_o  = nx_s6;
	assign ny_o  = ny_s6;
	assign rad_o = rad_s6;
	assign px_o  = px_s6;
	assign py_o  = py_s6;

endmodule
`default_nettype wire

// ===== rtl/tltt_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tltt_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tltt_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  logic [tltt_pkg::RAD_W-1:0]    rad,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          v_out,
	output logic [tltt_pkg::ROOT_W-1:0]   root,
	output logic [SIDE_W-1:0]             side_out
);
	import tltt_pkg::*;

	localparam int STEPS = ROOT_W;
	localparam int PAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic              v_r    [STEPS];
	logic [PAD_W-1:0]  rad_r  [STEPS];
	logic [REM_W-1:0]  rem_r  [STEPS];
	logic [ROOT_W-1:0] root_r [STEPS];
	logic [SIDE_W-1:0] side_r [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic              cur_v;
		logic [PAD_W-1:0]  cur_rad;
		logic [REM_W-1:0]  cur_rem;
		logic [ROOT_W-1:0] cur_root;
		logic [SIDE_W-1:0] cur_side;
		logic [REM_W-1:0]  rem_sh, trial;

		if (k == 0) begin : g_first
			assign cur_v    = v_in;
			assign cur_rad  = PAD_W'(rad);
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_v    = v_r[k-1];
			assign cur_rad  = rad_r[k-1];
			assign cur_rem  = rem_r[k-1];
			assign cur_root = root_r[k-1];
			assign cur_side = side_r[k-1];
		end

		always_comb begin
			rem_sh = {cur_rem[REM_W-3:0], cur_rad[PAD_W-1-2*k -: 2]};
			trial  = {cur_root, 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_r[k] <= 1'b0;
			end else if (en) begin
				v_r[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_r[k]  <= cur_rad;
				side_r[k] <= cur_side;
				if (rem_sh >= trial) begin
					rem_r[k]  <= rem_sh - trial;
					root_r[k] <= {cur_root[ROOT_W-2:0], 1'b1};
				end else begin
					rem_r[k]  <= rem_sh;
					root_r[k] <= {cur_root[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign v_out    = v_r[STEPS-1];
	assign root     = root_r[STEPS-1];
	assign side_out = side_r[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/tltt_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tltt_div
// Two restoring dividers sharing one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tltt_div #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  logic [tltt_pkg::NUM_W-1:0]    num_x,
	input  logic [tltt_pkg::NUM_W-1:0]    num_y,
	input  logic [tltt_pkg::DEN_W-1:0]    den,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          v_out,
	output logic [tltt_pkg::QUO_W-1:0]    qx,
	output logic [tltt_pkg::QUO_W-1:0]    qy,
	output logic [SIDE_W-1:0]             side_out
);
	import tltt_pkg::*;

	localparam int STEPS = QUO_W;
	localparam int CMP_W = DEN_W + QUO_W;

	logic              v_r    [STEPS];
	logic [NUM_W-1:0]  remx_r [STEPS];
	logic [NUM_W-1:0]  remy_r [STEPS];
	logic [QUO_W-1:0]  qx_r   [STEPS];
	logic [QUO_W-1:0]  qy_r   [STEPS];
	logic [DEN_W-1:0]  den_r  [STEPS];
	logic [SIDE_W-1:0] side_r [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic              cur_v;
		logic [NUM_W-1:0]  cur_rx, cur_ry;
		logic [QUO_W-1:0]  cur_qx, cur_qy;
		logic [DEN_W-1:0]  cur_den;
		logic [SIDE_W-1:0] cur_side;
		logic [CMP_W-1:0]  dsh;
		logic              bx, by;

		if (k == 0) begin : g_first
			assign cur_v    = v_in;
			assign cur_rx   = num_x;
			assign cur_ry   = num_y;
			assign cur_qx   = '0;
			assign cur_qy   = '0;
			assign cur_den  = den;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_v    = v_r[k-1];
			assign cur_rx   = remx_r[k-1];
			assign cur_ry   = remy_r[k-1];
			assign cur_qx   = qx_r[k-1];
			assign cur_qy   = qy_r[k-1];
			assign cur_den  = den_r[k-1];
			assign cur_side = side_r[k-1];
		end

		always_comb begin
			dsh = CMP_W'(cur_den) << (STEPS - 1 - k);
			bx  = CMP_W'(cur_rx) >= dsh;
			by  = CMP_W'(cur_ry) >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_r[k] <= 1'b0;
			end else if (en) begin
				v_r[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_r[k]  <= cur_den;
				side_r[k] <= cur_side;
				remx_r[k] <= bx ? cur_rx - dsh[NUM_W-1:0] : cur_rx;
				remy_r[k] <= by ? cur_ry - dsh[NUM_W-1:0] : cur_ry;
				qx_r[k]   <= {cur_qx[QUO_W-2:0], bx};
				qy_r[k]   <= {cur_qy[QUO_W-2:0], by};
			end
		end
	end

	assign v_out    = v_r[STEPS-1];
	assign qx       = qx_r[STEPS-1];
	assign qy       = qy_r[STEPS-1];
	assign side_out = side_r[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/thick_line_to_triangles.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thick_line_to_triangles
// Expands a segment and a thickness into the two triangles of a thick line.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  --------+-----+-------------------------------------------------------
//  seg     | in  | start_x/y, end_x/y, thickness (one segment per request)
//  tris    | out | three vertices, tri_color, last_triangle (two per seg)
//  apb     | in  | geom_color at bytes 0-3, writes only take effect there
//
//  A segment request can be taken every cycle the pipe advances; each one
//  occupies the output register until both of its triangles are taken,
//  one after the other. The path to the first triangle runs through
//  6 front stages, 32 root stages, 1 numerator stage, 16 divider stages,
//  1 offset stage and the output register.
//  Reset clears all valid bits and sets geom_color to all ones.
//  The whole pipe holds while the output register keeps an undelivered
//  triangle, so nothing is dropped or repeated under backpressure.
// ----------------------------------------------------------------------------
module thick_line_to_triangles #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tltt_seg_if.sink                       seg,
	tltt_tri_if.source                     tris,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tltt_pkg::PADDR_W-1:0]   paddr,
	input  logic [tltt_pkg::APB_W-1:0]     pwdata,
	output logic [tltt_pkg::APB_W-1:0]     prdata,
	output logic                           pready
);
	import tltt_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int SUM_W = ((CW > OFS_W) ? CW : OFS_W) + 1;

	typedef struct packed {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
		logic                 nx;
		logic                 ny;
	} seg_side_t;

	typedef struct packed {
		seg_side_t         geo;
		logic [PROD_W-1:0] px;
		logic [PROD_W-1:0] py;
	} root_side_t;

	// saturate a corner sum to the coordinate range
	function automatic logic [CW-1:0] sat_c(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi, lo;
		hi = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
		lo = ~hi;
		if (v > hi) return hi[CW-1:0];
		else if (v < lo) return lo[CW-1:0];
		else return v[CW-1:0];
	endfunction

	// ---------------- configuration ----------------
	logic [COLOR_W-1:0] color_q;
	logic               cfg_hit;

	assign cfg_hit = paddr[PADDR_W-1:REG_IDX_LSB] == REG_GEOM_COLOR;
	assign pready  = 1'b1;
	assign prdata  = cfg_hit ? APB_W'(color_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RST;
		end else if (psel && penable && pwrite && cfg_hit) begin
			color_q <= pwdata[COLOR_W-1:0];
		end
	end

	// ---------------- pipe advance ----------------
	// adv moves every stage at once; it is low only while the output
	// register still owes a triangle of the current pair.
	logic     adv;
	logic     ev_q;
	tri_sel_t ph_q;

	assign adv       = !ev_q || (tris.ready && ph_q == TRI_SECOND);
	assign seg.ready = adv;

	// ---------------- front: normalize, square, multiply ----------------
	logic              v_f;
	seg_side_t         geo_f;
	logic [RAD_W-1:0]  rad_f;
	logic [PROD_W-1:0] px_f, py_f;

	tltt_front #(.CW(CW)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_in   (seg.valid),
		.sx     (seg.start_x),
		.sy     (seg.start_y),
		.ex     (seg.end_x),
		.ey     (seg.end_y),
		.th     (seg.thickness),
		.v_out  (v_f),
		.sx_o   (geo_f.sx),
		.sy_o   (geo_f.sy),
		.ex_o   (geo_f.ex),
		.ey_o   (geo_f.ey),
		.nx_o   (geo_f.nx),
		.ny_o   (geo_f.ny),
		.rad_o  (rad_f),
		.px_o   (px_f),
		.py_o   (py_f)
	);

	// ---------------- length ----------------
	root_side_t        rs_in, rs_out;
	logic              v_r;
	logic [ROOT_W-1:0] len_r;

	assign rs_in = '{geo: geo_f, px: px_f, py: py_f};

	tltt_sqrt #(.SIDE_W($bits(root_side_t))) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.v_in     (v_f),
		.rad      (rad_f),
		.side_in  (rs_in),
		.v_out    (v_r),
		.root     (len_r),
		.side_out (rs_out)
	);

	// ---------------- rounding numerators ----------------
	// round(p*64/L) = floor((p*128 + L) / (2L))
	logic             v_n;
	seg_side_t        geo_n;
	logic [NUM_W-1:0] numx_n, numy_n;
	logic [DEN_W-1:0] den_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n <= 1'b0;
		end else if (adv) begin
			v_n <= v_r;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_n  <= rs_out.geo;
			numx_n <= (NUM_W'(rs_out.px) << NUM_SH) + NUM_W'(len_r);
			numy_n <= (NUM_W'(rs_out.py) << NUM_SH) + NUM_W'(len_r);
			den_n  <= {len_r, 1'b0};
		end
	end

	// ---------------- offset magnitudes ----------------
	logic             v_d;
	seg_side_t        geo_d;
	logic [QUO_W-1:0] qx_d, qy_d;

	tltt_div #(.SIDE_W($bits(seg_side_t))) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.v_in     (v_n),
		.num_x    (numx_n),
		.num_y    (numy_n),
		.den      (den_n),
		.side_in  (geo_n),
		.v_out    (v_d),
		.qx       (qx_d),
		.qy       (qy_d),
		.side_out (geo_d)
	);

	// ---------------- signed offsets ----------------
	// x offset follows sign of dy, y offset the opposite of dx
	logic                    v_o;
	seg_side_t               geo_o;
	logic signed [OFS_W-1:0] ox_o, oy_o, qxs, qys;

	assign qxs = {1'b0, qx_d};
	assign qys = {1'b0, qy_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (adv) begin
			v_o <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_o <= geo_d;
			ox_o  <= geo_d.ny ? -qxs : qxs;
			oy_o  <= geo_d.nx ? qys : -qys;
		end
	end

	// ---------------- corners into the output register ----------------
	logic signed [SUM_W-1:0] sxw, syw, exw, eyw, oxw, oyw;
	logic [CW-1:0] tlx_q, tly_q, trx_q, try_q, blx_q, bly_q, brx_q, bry_q;

	assign sxw = SUM_W'(geo_o.sx);
	assign syw = SUM_W'(geo_o.sy);
	assign exw = SUM_W'(geo_o.ex);
	assign eyw = SUM_W'(geo_o.ey);
	assign oxw = SUM_W'(ox_o);
	assign oyw = SUM_W'(oy_o);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= 1'b0;
			ph_q <= TRI_FIRST;
		end else if (adv) begin
			ev_q <= v_o;
			ph_q <= TRI_FIRST;
		end else if (tris.ready) begin
			ph_q <= TRI_SECOND;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tlx_q <= sat_c(sxw + oxw);
			tly_q <= sat_c(syw + oyw);
			trx_q <= sat_c(exw + oxw);
			try_q <= sat_c(eyw + oyw);
			blx_q <= sat_c(sxw - oxw);
			bly_q <= sat_c(syw - oyw);
			brx_q <= sat_c(exw - oxw);
			bry_q <= sat_c(eyw - oyw);
		end
	end

	// first triangle (tl,tr,bl), second (tr,br,bl)
	assign tris.valid         = ev_q;
	assign tris.vert_a_x      = (ph_q == TRI_SECOND) ? trx_q : tlx_q;
	assign tris.vert_a_y      = (ph_q == TRI_SECOND) ? try_q : tly_q;
	assign tris.vert_b_x      = (ph_q == TRI_SECOND) ? brx_q : trx_q;
	assign tris.vert_b_y      = (ph_q == TRI_SECOND) ? bry_q : try_q;
	assign tris.vert_c_x      = blx_q;
	assign tris.vert_c_y      = bly_q;
	assign tris.tri_color     = color_q;
	assign tris.last_triangle = ph_q == TRI_SECOND;

endmodule
`default_nettype wire
